/* hdl/itoa_pkg.sv */
package itoa_pkg;

    localparam int INPUT_BITS = 64;
    localparam int VALUE_BITS = 64;
    localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int DIG_W      = DEC_DIGITS * 4;
    localparam int HEX_W      = HEX_DIGITS * 4;
    localparam int BIT_CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int DIG_CNT_W  = $clog2(DEC_DIGITS + 1);

    localparam logic [1:0] KIND_SIGNED = 2'd0;
    localparam logic [1:0] KIND_HEX    = 2'd2;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_X     = 8'h78;

    localparam logic [7:0] DIGIT_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_PRE,
        ST_DIG
    } state_t;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic skip_step;
        logic emit_pre;
        logic emit_dig;
    } cmd_t;

    typedef struct packed {
        logic conv_done;
        logic top_zero;
        logic one_left;
        logic pre_done;
        logic out_free;
    } sts_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        return DIGIT_CHARS[d];
    endfunction

endpackage

/* hdl/itoa_ctrl.sv */
module itoa_ctrl
    import itoa_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (sts.conv_done) begin
                    state_next = ST_SKIP;
                end else begin
                    cmd.conv_step = 1'b1;
                end
            end
            ST_SKIP: begin
                if (sts.top_zero && !sts.one_left) begin
                    cmd.skip_step = 1'b1;
                end else begin
                    state_next = ST_PRE;
                end
            end
            ST_PRE: begin
                if (sts.pre_done) begin
                    state_next = ST_DIG;
                end else if (sts.out_free) begin
                    cmd.emit_pre = 1'b1;
                end
            end
            ST_DIG: begin
                if (sts.out_free) begin
                    cmd.emit_dig = 1'b1;
                    if (sts.one_left) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/itoa_dp.sv */
module itoa_dp
    import itoa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [1:0]            s_kind,
    input  logic [INPUT_BITS-1:0] s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_text_char,
    output logic                  m_last,
    input  cmd_t                  cmd,
    output sts_t                  sts
);

    logic                  hex_reg,     hex_next;
    logic [VALUE_BITS-1:0] mag_reg,     mag_next;
    logic [DIG_W-1:0]      dig_reg,     dig_next;
    logic [BIT_CNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]  dig_cnt_reg, dig_cnt_next;
    logic [1:0]            pre_cnt_reg, pre_cnt_next;
    logic                  valid_reg,   valid_next;
    logic [7:0]            char_reg,    char_next;
    logic                  last_reg,    last_next;

    logic [VALUE_BITS-1:0] in_val;
    logic                  in_neg;
    logic [HEX_W-1:0]      hex_pad;
    logic [DIG_W-1:0]      adj;
    logic [3:0]            top_dig;

    assign in_val  = s_value[VALUE_BITS-1:0];
    assign in_neg  = (s_kind == KIND_SIGNED) && in_val[VALUE_BITS-1];
    assign hex_pad = HEX_W'(in_val);
    assign top_dig = dig_reg[DIG_W-1 -: 4];

    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            if (dig_reg[i*4 +: 4] >= 4'd5) begin
                adj[i*4 +: 4] = dig_reg[i*4 +: 4] + 4'd3;
            end else begin
                adj[i*4 +: 4] = dig_reg[i*4 +: 4];
            end
        end
    end

    assign sts.conv_done = (bit_cnt_reg == '0);
    assign sts.top_zero  = (top_dig == 4'd0);
    assign sts.one_left  = (dig_cnt_reg == DIG_CNT_W'(1));
    assign sts.pre_done  = (pre_cnt_reg == 2'd0);
    assign sts.out_free  = !valid_reg || m_ready;

    always_comb begin
        hex_next     = hex_reg;
        mag_next     = mag_reg;
        dig_next     = dig_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        pre_cnt_next = pre_cnt_reg;
        valid_next   = valid_reg && !m_ready;
        char_next    = char_reg;
        last_next    = last_reg;

        if (cmd.load) begin
            hex_next     = (s_kind == KIND_HEX);
            mag_next     = in_neg ? (~in_val + VALUE_BITS'(1)) : in_val;
            if (s_kind == KIND_HEX) begin
                dig_next     = DIG_W'(hex_pad) << (DIG_W - HEX_W);
                bit_cnt_next = '0;
                dig_cnt_next = DIG_CNT_W'(HEX_DIGITS);
                pre_cnt_next = 2'd2;
            end else begin
                dig_next     = '0;
                bit_cnt_next = BIT_CNT_W'(VALUE_BITS);
                dig_cnt_next = DIG_CNT_W'(DEC_DIGITS);
                pre_cnt_next = in_neg ? 2'd1 : 2'd0;
            end
        end

        if (cmd.conv_step) begin
            dig_next     = {adj[DIG_W-2:0], mag_reg[VALUE_BITS-1]};
            mag_next     = mag_reg << 1;
            bit_cnt_next = bit_cnt_reg - BIT_CNT_W'(1);
        end

        if (cmd.skip_step || cmd.emit_dig) begin
            dig_next     = dig_reg << 4;
            dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
        end

        if (cmd.emit_pre) begin
            valid_next   = 1'b1;
            last_next    = 1'b0;
            pre_cnt_next = pre_cnt_reg - 2'd1;
            if (!hex_reg) begin
                char_next = CHAR_MINUS;
            end else if (pre_cnt_reg == 2'd2) begin
                char_next = CHAR_ZERO;
            end else begin
                char_next = CHAR_X;
            end
        end

        if (cmd.emit_dig) begin
            valid_next = 1'b1;
            char_next  = digit_char(top_dig);
            last_next  = sts.one_left;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
            pre_cnt_reg <= 2'd0;
        end else begin
            valid_reg   <= valid_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
            pre_cnt_reg <= pre_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        hex_reg  <= hex_next;
        mag_reg  <= mag_next;
        dig_reg  <= dig_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign m_valid     = valid_reg;
    assign m_text_char = char_reg;
    assign m_last      = last_reg;

endmodule

/* hdl/integer_to_ascii_converter.sv */
// Sequence: a decimal value runs the shift-and-add-3 conversion, one step per value bit (64),
// then suppresses leading zeros, then loads the characters one by one as the output register frees.
// Hex skips the conversion.
// Throughput: one value at a time; the next is taken once the last character is loaded.
// Reset: synchronous active-low aresetn returns to idle and empties the output register.
module integer_to_ascii_converter
    import itoa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_kind,
    input  logic [INPUT_BITS-1:0] s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_text_char,
    output logic                  m_last
);

    cmd_t cmd;
    sts_t sts;

    itoa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    itoa_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_kind      (s_kind),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_text_char (m_text_char),
        .m_last      (m_last),
        .cmd         (cmd),
        .sts         (sts)
    );

`ifndef SYNTHESIS
    a_emit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_pre || cmd.emit_dig) |-> sts.out_free)
        else $error("character loaded while the output register was occupied");

    a_last_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_dig && sts.one_left) |=> s_ready)
        else $error("controller did not return to idle after the last digit");

    a_accept_then_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted twice in a row");

    a_last_flag_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_dig |=> (m_last == $past(sts.one_left)))
        else $error("last flag does not match the digit count");
`endif

endmodule

/* tb/integer_to_ascii_converter_tb.sv */
`timescale 1ns / 100ps

module integer_to_ascii_converter_tb;
    import itoa_pkg::*;

    localparam logic [1:0] KIND_UNSIGNED = 2'd1;
    localparam logic [1:0] KIND_SPARE    = 2'd3;
    localparam logic [INPUT_BITS-1:0] VALUE_MASK = {INPUT_BITS{1'b1}} >> (INPUT_BITS - VALUE_BITS);
    localparam logic [INPUT_BITS-1:0] MOST_NEG   = {{(INPUT_BITS-1){1'b0}}, 1'b1} << (VALUE_BITS - 1);
    localparam int SETTLE_CYCLES = 200;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } text_char_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_kind = KIND_SIGNED;
    logic [INPUT_BITS-1:0] s_value = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [7:0]            m_text_char;
    logic                  m_last;

    text_char_t pending_chars[$];
    int         mismatches = 0;
    bit         quiet = 1'b0;
    int         hold_cycles = 0;

    integer_to_ascii_converter dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_text_char (m_text_char),
        .m_last      (m_last)
    );

    always #4 aclk = ~aclk;

    function automatic logic [7:0] digit_code(input logic [3:0] d);
        if (d < 4'd10) begin
            return 8'h30 + d;
        end
        return 8'h41 + (d - 4'd10);
    endfunction

    function automatic void format_text(input logic [1:0] kind, input logic [INPUT_BITS-1:0] value);
        logic [INPUT_BITS-1:0] word;
        logic [INPUT_BITS-1:0] mag;
        logic [INPUT_BITS-1:0] radix;
        logic [7:0]            text[$];
        logic [7:0]            digits[$];
        text_char_t            entry;
        word = value & VALUE_MASK;
        mag = word;
        radix = (kind == KIND_HEX) ? INPUT_BITS'(16) : INPUT_BITS'(10);
        if (kind == KIND_HEX) begin
            text.push_back(CHAR_ZERO);
            text.push_back(CHAR_X);
        end else if (kind == KIND_SIGNED && word[VALUE_BITS-1]) begin
            text.push_back(CHAR_MINUS);
            mag = (~word + 1'b1) & VALUE_MASK;
            if (mag == '0) begin
                mag = word;
            end
        end
        do begin
            digits.push_front(digit_code(4'(mag % radix)));
            mag = mag / radix;
        end while (mag != '0);
        foreach (digits[i]) begin
            text.push_back(digits[i]);
        end
        foreach (text[i]) begin
            entry.code = text[i];
            entry.last = (i == text.size() - 1);
            pending_chars.push_back(entry);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
        if (mismatches < 50) begin
            $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        end
        mismatches++;
    endtask

    always @(posedge aclk) begin
        text_char_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_chars.size() == 0) begin
                report_mismatch("unexpected character", m_text_char, 8'h00);
            end else begin
                want = pending_chars.pop_front();
                if (m_text_char !== want.code) begin
                    report_mismatch("text_char", m_text_char, want.code);
                end
                if (m_last !== want.last) begin
                    report_mismatch("last", {7'd0, m_last}, {7'd0, want.last});
                end
            end
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else if (quiet) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 22);
            end
        end
    end

    task automatic send_value(input logic [1:0] kind, input logic [INPUT_BITS-1:0] value);
        int gap;
        gap = (!quiet && $urandom_range(99) < 22) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        format_text(kind, value);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [INPUT_BITS-1:0] power_of_ten(input int k);
        logic [INPUT_BITS-1:0] p;
        p = INPUT_BITS'(1);
        for (int i = 0; i < k; i++) begin
            p = p * INPUT_BITS'(10);
        end
        return p;
    endfunction

    function automatic logic [INPUT_BITS-1:0] random_word();
        logic [INPUT_BITS-1:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(3))
            0: return w;
            1: return w >> $urandom_range(INPUT_BITS - 1);
            2: return -(w >> $urandom_range(INPUT_BITS - 1));
            default: return power_of_ten($urandom_range(19)) + $urandom_range(2) - 1;
        endcase
    endfunction

    function automatic logic [1:0] random_kind();
        int r;
        r = $urandom_range(9);
        if (r < 4) begin
            return KIND_SIGNED;
        end else if (r < 7) begin
            return KIND_UNSIGNED;
        end else if (r < 9) begin
            return KIND_HEX;
        end
        return KIND_SPARE;
    endfunction

    task automatic test_signed_extremes();
        send_value(KIND_SIGNED, '0);
        send_value(KIND_SIGNED, 1);
        send_value(KIND_SIGNED, '1);
        send_value(KIND_SIGNED, ~MOST_NEG & VALUE_MASK);
        send_value(KIND_SIGNED, MOST_NEG);
        send_value(KIND_SIGNED, -10);
        send_value(KIND_SIGNED, 64'd9876543210123456789);
    endtask

    task automatic test_unsigned_extremes();
        send_value(KIND_UNSIGNED, '0);
        send_value(KIND_UNSIGNED, '1);
        send_value(KIND_UNSIGNED, 64'd9876543210123456789);
        send_value(KIND_UNSIGNED, 10);
    endtask

    task automatic test_hex_extremes();
        send_value(KIND_HEX, '0);
        send_value(KIND_HEX, '1);
        send_value(KIND_HEX, 64'h0123456789ABCDEF);
        send_value(KIND_HEX, 64'hFEDCBA9876543210);
        send_value(KIND_HEX, MOST_NEG);
    endtask

    task automatic test_spare_kind();
        send_value(KIND_SPARE, '0);
        send_value(KIND_SPARE, '1);
        send_value(KIND_SPARE, MOST_NEG);
    endtask

    task automatic test_back_to_back();
        quiet = 1'b1;
        repeat (20) send_value(random_kind(), random_word());
        quiet = 1'b0;
    endtask

    task automatic test_output_backpressure();
        hold_cycles = 300;
        repeat (6) send_value(random_kind(), random_word());
        wait_drained();
    endtask

    task automatic test_random_values();
        repeat (55) send_value(random_kind(), random_word());
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_signed_extremes();
        test_unsigned_extremes();
        test_hex_extremes();
        test_spare_kind();
        test_back_to_back();
        test_output_backpressure();
        test_random_values();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_chars.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
